>>> hw/rtl/radix2_complex_fft_top_defines.svh
// ----------------------------------------------------------------------------
// Radix-2 FFT assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RADIX2_COMPLEX_FFT_TOP_DEFINES_SVH
`define RADIX2_COMPLEX_FFT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define R2FFT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("r2fft: check failed");
`define R2FFT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("r2fft: check failed");
`else
`define R2FFT_ASSERT(lbl, clk, rst_n, prop)
`define R2FFT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hw/rtl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// Radix-2 FFT package
// Request types, sample format, twiddle table and saturation helpers.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int POINTS_DEF = 16;
  localparam int IN_W       = 16;
  localparam int DATA_W     = 20;
  localparam int TW_W       = 18;
  localparam int IDX_W      = 6;
  localparam int PROD_W     = DATA_W + TW_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC_W     = 17;
  localparam int T_W        = ACC_W - FRAC_W;
  localparam int SUM_W      = T_W + 1;

  typedef struct packed {
    logic signed [IN_W-1:0] sample_real;
    logic signed [IN_W-1:0] sample_imag;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] bin_real;
    logic signed [DATA_W-1:0] bin_imag;
    logic [IDX_W-1:0]         bin_index;
    logic                     last_bin;
  } out_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic signed [TW_W-1:0] re;
    logic signed [TW_W-1:0] im;
  } tw_t;

  typedef struct packed {
    logic cap_a;
    logic mul_en;
    logic rnd_en;
  } bfly_ctl_t;

  localparam int RAM_W = $bits(cplx_t);

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(524287);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(524288);

  function automatic logic signed [TW_W-1:0] sine_rom(input logic [4:0] idx);
    logic signed [TW_W-1:0] v;
    case (idx)
      5'd0:    v = 18'sd0;
      5'd1:    v = 18'sd12847;
      5'd2:    v = 18'sd25571;
      5'd3:    v = 18'sd38048;
      5'd4:    v = 18'sd50159;
      5'd5:    v = 18'sd61787;
      5'd6:    v = 18'sd72820;
      5'd7:    v = 18'sd83151;
      5'd8:    v = 18'sd92682;
      5'd9:    v = 18'sd101320;
      5'd10:   v = 18'sd108982;
      5'd11:   v = 18'sd115595;
      5'd12:   v = 18'sd121095;
      5'd13:   v = 18'sd125428;
      5'd14:   v = 18'sd128553;
      5'd15:   v = 18'sd130441;
      5'd16:   v = 18'sd131071;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  // angle in units of 2*pi/64, half circle
  function automatic tw_t twiddle(input logic [4:0] angle, input logic inverse);
    tw_t                    w;
    logic signed [TW_W-1:0] s;
    logic signed [TW_W-1:0] c;
    if (angle <= 5'd16) begin
      s = sine_rom(angle);
      c = sine_rom(5'd16 - angle);
    end else begin
      s = sine_rom(5'd0 - angle);
      c = -sine_rom(angle - 5'd16);
    end
    w.re = c;
    w.im = inverse ? s : -s;
    return w;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat20(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = DATA_W'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = DATA_W'(SAT_MIN);
    end else begin
      r = DATA_W'(v);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/r2fft_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int WIDTH = r2fft_pkg::RAM_W,
  parameter int DEPTH = r2fft_pkg::POINTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/r2fft_bfly.sv
// ----------------------------------------------------------------------------
// Radix-2 butterfly unit
// Complex multiply by twiddle, round, then saturated sum and difference.
// ----------------------------------------------------------------------------
module r2fft_bfly (
  input  logic                 clk,
  input  r2fft_pkg::bfly_ctl_t ctl,
  input  r2fft_pkg::cplx_t     rd_data,
  input  r2fft_pkg::tw_t       w,
  output r2fft_pkg::cplx_t     sum_o,
  output r2fft_pkg::cplx_t     diff_o
);

  localparam int PROD_W = r2fft_pkg::PROD_W;
  localparam int ACC_W  = r2fft_pkg::ACC_W;
  localparam int T_W    = r2fft_pkg::T_W;
  localparam int SUM_W  = r2fft_pkg::SUM_W;

  r2fft_pkg::cplx_t          a_r;
  logic signed [PROD_W-1:0]  p_rr_r;
  logic signed [PROD_W-1:0]  p_ii_r;
  logic signed [PROD_W-1:0]  p_ri_r;
  logic signed [PROD_W-1:0]  p_ir_r;
  logic signed [T_W-1:0]     t_re_r;
  logic signed [T_W-1:0]     t_im_r;
  logic signed [ACC_W-1:0]   acc_re;
  logic signed [ACC_W-1:0]   acc_im;

  always_comb begin
    acc_re = ACC_W'(p_rr_r) - ACC_W'(p_ii_r) + ACC_W'(65536);
    acc_im = ACC_W'(p_ri_r) + ACC_W'(p_ir_r) + ACC_W'(65536);
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      a_r <= rd_data;
    end
    if (ctl.mul_en) begin
      p_rr_r <= rd_data.re * w.re;
      p_ii_r <= rd_data.im * w.im;
      p_ri_r <= rd_data.re * w.im;
      p_ir_r <= rd_data.im * w.re;
    end
    if (ctl.rnd_en) begin
      t_re_r <= T_W'(acc_re >>> r2fft_pkg::FRAC_W);
      t_im_r <= T_W'(acc_im >>> r2fft_pkg::FRAC_W);
    end
  end

  always_comb begin
    sum_o.re  = r2fft_pkg::sat20(SUM_W'(a_r.re) + SUM_W'(t_re_r));
    sum_o.im  = r2fft_pkg::sat20(SUM_W'(a_r.im) + SUM_W'(t_im_r));
    diff_o.re = r2fft_pkg::sat20(SUM_W'(a_r.re) - SUM_W'(t_re_r));
    diff_o.im = r2fft_pkg::sat20(SUM_W'(a_r.im) - SUM_W'(t_im_r));
  end

endmodule

>>> hw/rtl/radix2_complex_fft_top.sv
// ----------------------------------------------------------------------------
// Radix-2 complex FFT top level
// Load: one sample per cycle into bit-reversed RAM slots, POINTS samples.
// Transform: each butterfly steps RD_A, RD_B, MUL, RND, WR_A, WR_B on the shared unit.
// Unload: per bin a RAM read, capture and handshake (U_RD, U_CAP, U_HOLD); no input meanwhile.
// Synchronous active-low reset clears sequencer, counters and direction to 0.
// ----------------------------------------------------------------------------
`include "radix2_complex_fft_top_defines.svh"

module radix2_complex_fft_top #(
  parameter int POINTS = r2fft_pkg::POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  r2fft_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output r2fft_pkg::out_req_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  localparam int LOG2 = $clog2(POINTS);
  localparam int AW   = LOG2;
  localparam int SW   = $clog2(LOG2 + 1);
  localparam int HALF = POINTS / 2;

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_RD_A   = 4'd1;
  localparam logic [3:0] ST_RD_B   = 4'd2;
  localparam logic [3:0] ST_MUL    = 4'd3;
  localparam logic [3:0] ST_RND    = 4'd4;
  localparam logic [3:0] ST_WR_A   = 4'd5;
  localparam logic [3:0] ST_WR_B   = 4'd6;
  localparam logic [3:0] ST_U_RD   = 4'd7;
  localparam logic [3:0] ST_U_CAP  = 4'd8;
  localparam logic [3:0] ST_U_HOLD = 4'd9;

  localparam logic [AW-1:0] CNT_LAST = AW'(POINTS - 1);
  localparam logic [AW-1:0] BF_LAST  = AW'(HALF - 1);
  localparam logic [SW-1:0] STG_LAST = SW'(LOG2 - 1);

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       bf_r, bf_nxt;
  logic [SW-1:0]       stage_r, stage_nxt;
  logic                dir_r, dir_nxt;
  logic                cfg_dir_r;
  logic                out_valid_r, out_valid_nxt;
  r2fft_pkg::out_req_t out_r, out_nxt;
  r2fft_pkg::tw_t      w_r, w_nxt;

  logic                in_acc;
  logic                out_acc;
  logic [AW-1:0]       rev_addr;
  logic [AW-1:0]       lo_mask;
  logic [AW-1:0]       addr_a;
  logic [AW-1:0]       addr_b;
  logic [5:0]          j6;
  logic [4:0]          angle;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  r2fft_pkg::cplx_t       ram_wdata;
  logic [AW-1:0]          ram_raddr;
  r2fft_pkg::cplx_t       ram_rdata;
  r2fft_pkg::bfly_ctl_t   bfly_ctl;
  r2fft_pkg::cplx_t       bfly_sum;
  r2fft_pkg::cplx_t       bfly_diff;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_acc   = out_valid_r && !out_stall;

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      rev_addr[i] = cnt_r[AW-1-i];
    end
  end

  always_comb begin
    lo_mask = (AW'(1) << stage_r) - AW'(1);
    addr_a  = AW'({bf_r & ~lo_mask, 1'b0}) | (bf_r & lo_mask);
    addr_b  = addr_a | (AW'(1) << stage_r);
    j6      = 6'(bf_r & lo_mask);
    angle   = 5'(j6 << (3'd5 - 3'(stage_r)));
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bf_nxt        = bf_r;
    stage_nxt     = stage_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    w_nxt         = w_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_a;
    ram_wdata     = bfly_sum;
    ram_raddr     = addr_a;
    bfly_ctl      = '0;
    case (state_r)
      ST_LOAD: begin
        ram_waddr    = rev_addr;
        ram_wdata.re = r2fft_pkg::DATA_W'(in_data.sample_real);
        ram_wdata.im = r2fft_pkg::DATA_W'(in_data.sample_imag);
        if (in_acc) begin
          ram_we = 1'b1;
          if (cnt_r == CNT_LAST) begin
            cnt_nxt   = '0;
            bf_nxt    = '0;
            stage_nxt = '0;
            dir_nxt   = cfg_dir_r;
            state_nxt = ST_RD_A;
          end else begin
            cnt_nxt = cnt_r + AW'(1);
          end
        end
      end
      ST_RD_A: begin
        w_nxt     = r2fft_pkg::twiddle(angle, dir_r);
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        ram_raddr      = addr_b;
        bfly_ctl.cap_a = 1'b1;
        state_nxt      = ST_MUL;
      end
      ST_MUL: begin
        bfly_ctl.mul_en = 1'b1;
        state_nxt       = ST_RND;
      end
      ST_RND: begin
        bfly_ctl.rnd_en = 1'b1;
        state_nxt       = ST_WR_A;
      end
      ST_WR_A: begin
        ram_we    = 1'b1;
        state_nxt = ST_WR_B;
      end
      ST_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = bfly_diff;
        if (bf_r == BF_LAST) begin
          bf_nxt = '0;
          if (stage_r == STG_LAST) begin
            stage_nxt = '0;
            state_nxt = ST_U_RD;
          end else begin
            stage_nxt = stage_r + SW'(1);
            state_nxt = ST_RD_A;
          end
        end else begin
          bf_nxt    = bf_r + AW'(1);
          state_nxt = ST_RD_A;
        end
      end
      ST_U_RD: begin
        ram_raddr = cnt_r;
        state_nxt = ST_U_CAP;
      end
      ST_U_CAP: begin
        out_nxt.bin_real  = ram_rdata.re;
        out_nxt.bin_imag  = ram_rdata.im;
        out_nxt.bin_index = r2fft_pkg::IDX_W'(cnt_r);
        out_nxt.last_bin  = (cnt_r == CNT_LAST);
        out_valid_nxt     = 1'b1;
        state_nxt         = ST_U_HOLD;
      end
      ST_U_HOLD: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (cnt_r == CNT_LAST) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt   = cnt_r + AW'(1);
            state_nxt = ST_U_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      bf_r        <= '0;
      stage_r     <= '0;
      dir_r       <= 1'b0;
      cfg_dir_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bf_r        <= bf_nxt;
      stage_r     <= stage_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_dir_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    w_r   <= w_nxt;
  end

  r2fft_ram #(
    .WIDTH (r2fft_pkg::RAM_W),
    .DEPTH (POINTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  r2fft_bfly u_bfly (
    .clk     (clk),
    .ctl     (bfly_ctl),
    .rd_data (ram_rdata),
    .w       (w_r),
    .sum_o   (bfly_sum),
    .diff_o  (bfly_diff)
  );

  `R2FFT_ASSERT(a_last_sample_starts, clk, rst_n, (in_acc && cnt_r == CNT_LAST) |=> (state_r == ST_RD_A && bf_r == '0 && stage_r == '0))
  `R2FFT_ASSERT(a_last_bin_reloads, clk, rst_n, (out_acc && out_r.last_bin) |=> (state_r == ST_LOAD && cnt_r == '0))
  `R2FFT_ASSERT(a_wr_b_after_wr_a, clk, rst_n, (state_r == ST_WR_B) |-> ($past(state_r) == ST_WR_A))
  `R2FFT_ASSERT(a_no_input_while_output, clk, rst_n, out_valid_r |-> in_stall)

endmodule
